// File: hw/rtl/gaussian_highpass_5x5_macros.svh
// ---------------------------------------------------------------------------
// gaussian high-pass assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_HIGHPASS_5X5_MACROS_SVH
`define GAUSSIAN_HIGHPASS_5X5_MACROS_SVH

// property that must hold at every edge out of reset
`define GHP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ghp_pkg.sv
// ---------------------------------------------------------------------------
// ghp_pkg
// shared constants, register codes and types of the 5x5 gaussian high-pass
// ---------------------------------------------------------------------------
package ghp_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 11;
	localparam int WGT_W     = 16;
	localparam int COORD_W   = 10;
	localparam int SUM_W     = 11;
	localparam int NUM_CLASS = 6;
	localparam int CLASS_W   = 3;
	localparam int KW        = 5;
	localparam int KERN_HALF = 2;
	localparam int NUM_ROWS  = 4;
	localparam int RSEL_W    = 2;
	localparam int MIN_SIZE  = 5;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_WEIGHT_CENTER = 3'd2;
	localparam logic [2:0] REG_WEIGHT_EDGE1  = 3'd3;
	localparam logic [2:0] REG_WEIGHT_DIAG1  = 3'd4;
	localparam logic [2:0] REG_WEIGHT_EDGE2  = 3'd5;
	localparam logic [2:0] REG_WEIGHT_KNIGHT = 3'd6;
	localparam logic [2:0] REG_WEIGHT_CORNER = 3'd7;

	localparam logic [SIZE_W-1:0] RST_SIZE = 11'd1024;
	localparam logic [WGT_W-1:0] RST_WEIGHT [NUM_CLASS] = '{
		16'd10624, 16'd6443, 16'd3908, 16'd1438, 16'd872, 16'd195
	};

	// weight class of each window tap, by squared distance from the centre
	localparam logic [CLASS_W-1:0] CLASS_MAP [KW][KW] = '{
		'{3'd5, 3'd4, 3'd3, 3'd4, 3'd5},
		'{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
		'{3'd3, 3'd1, 3'd0, 3'd1, 3'd3},
		'{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
		'{3'd5, 3'd4, 3'd3, 3'd4, 3'd5}
	};

	// one line-memory word: the four stored rows at one column
	typedef logic [NUM_ROWS-1:0][PIX_W-1:0] row_word_t;

	typedef struct packed {
		logic [SIZE_W-1:0]                 image_width;
		logic [SIZE_W-1:0]                 image_height;
		logic [NUM_CLASS-1:0][WGT_W-1:0]   weight;
	} cfg_t;

endpackage

// File: hw/rtl/ghp_line_buf.sv
// ---------------------------------------------------------------------------
// ghp_line_buf
// line memory, one word of four row bytes per column, with write bypass
// ---------------------------------------------------------------------------
module ghp_line_buf
	import ghp_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output row_word_t       rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  row_word_t       wr_data
);

	row_word_t mem [DEPTH];
	row_word_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// same column written this edge: take the new word
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// File: hw/rtl/ghp_regs.sv
// ---------------------------------------------------------------------------
// ghp_regs
// apb register file: image size and the six gaussian class weights
// ---------------------------------------------------------------------------
module ghp_regs
	import ghp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_SIZE;
			cfg_q.image_height <= RST_SIZE;
			for (int k = 0; k < NUM_CLASS; k++) begin
				cfg_q.weight[k] <= RST_WEIGHT[k];
			end
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_IMAGE_WIDTH:   cfg_q.image_width  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height <= pwdata[SIZE_W-1:0];
				REG_WEIGHT_CENTER: cfg_q.weight[0]    <= pwdata[WGT_W-1:0];
				REG_WEIGHT_EDGE1:  cfg_q.weight[1]    <= pwdata[WGT_W-1:0];
				REG_WEIGHT_DIAG1:  cfg_q.weight[2]    <= pwdata[WGT_W-1:0];
				REG_WEIGHT_EDGE2:  cfg_q.weight[3]    <= pwdata[WGT_W-1:0];
				REG_WEIGHT_KNIGHT: cfg_q.weight[4]    <= pwdata[WGT_W-1:0];
				REG_WEIGHT_CORNER: cfg_q.weight[5]    <= pwdata[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:   prdata = DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:  prdata = DATA_W'(cfg_q.image_height);
			REG_WEIGHT_CENTER: prdata = DATA_W'(cfg_q.weight[0]);
			REG_WEIGHT_EDGE1:  prdata = DATA_W'(cfg_q.weight[1]);
			REG_WEIGHT_DIAG1:  prdata = DATA_W'(cfg_q.weight[2]);
			REG_WEIGHT_EDGE2:  prdata = DATA_W'(cfg_q.weight[3]);
			REG_WEIGHT_KNIGHT: prdata = DATA_W'(cfg_q.weight[4]);
			REG_WEIGHT_CORNER: prdata = DATA_W'(cfg_q.weight[5]);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/gaussian_highpass_5x5.sv
// ---------------------------------------------------------------------------
// gaussian_highpass_5x5
// streaming 5x5 gaussian high-pass filter on 8-bit raster pixels
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and gives one
// result beat per pixel; the rate is set by the line memory, which does one
// read and one write-back per pixel (four row bytes per column word,
// read-modify-write with a bypass when the same column is touched on
// consecutive beats). Each result belongs to the window centred two rows
// and two columns behind the pixel; centres within two pixels of an edge
// give 0 and positions without a centre give all-zero fields with
// center_valid low. The line memory is not cleared after reset, so border
// centres of the first rows may see stale data, which is masked.
// ---------------------------------------------------------------------------
`include "gaussian_highpass_5x5_macros.svh"

module gaussian_highpass_5x5
	import ghp_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               frame_start,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [PIX_W-1:0]   hp_pixel,
	output logic [COORD_W-1:0] center_row,
	output logic [COORD_W-1:0] center_col,
	output logic               center_valid
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = (WW > SIZE_W) ? WW : SIZE_W;
	localparam int YW    = (HW > SIZE_W) ? HW : SIZE_W;
	localparam int CMPW  = XW + 1;
	localparam int RCMPW = YW + 1;
	localparam int PW    = WGT_W + SUM_W;
	localparam int PSW   = PW + 3;
	localparam int CTRW  = PIX_W + WEIGHT_BITS;
	localparam int ACC_W = ((CTRW > PSW) ? CTRW : PSW) + 2;
	localparam int QW    = ACC_W - WEIGHT_BITS;

	typedef struct packed {
		logic               interior;
		logic               cv;
		logic [COORD_W-1:0] cr;
		logic [COORD_W-1:0] cc;
	} meta_t;

	// configuration
	cfg_t cfg;

	ghp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// pipeline control
	logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
	logic ld1, ld2, ld3, ld4, ld5, ld_o;
	logic accept;

	assign ld_o      = !vo_q || res_ready;
	assign ld5       = !v5_q || ld_o;
	assign ld4       = !v4_q || ld5;
	assign ld3       = !v3_q || ld4;
	assign ld2       = !v2_q || ld3;
	assign ld1       = !v1_q || ld2;
	assign pix_ready = ld1;
	assign accept    = pix_valid && ld1;

	// size saturation and position counters
	logic [XW-1:0]    w_raw, w_sat;
	logic [YW-1:0]    h_raw, h_sat;
	logic [CW-1:0]    col_q, c_cur, c_next;
	logic [RW-1:0]    row_q, r_cur, r_next;
	logic [CMPW-1:0]  col_inc;
	logic [RCMPW-1:0] r_inc;
	logic             wrap;
	logic [RW-1:0]    cr_full;
	logic [CW-1:0]    cc_full;
	meta_t            meta_in;

	always_comb begin
		w_raw = XW'(cfg.image_width);
		h_raw = YW'(cfg.image_height);
		if (w_raw < XW'(MIN_SIZE)) begin
			w_sat = XW'(MIN_SIZE);
		end else if (w_raw > XW'(MAX_WIDTH)) begin
			w_sat = XW'(MAX_WIDTH);
		end else begin
			w_sat = w_raw;
		end
		if (h_raw < YW'(MIN_SIZE)) begin
			h_sat = YW'(MIN_SIZE);
		end else if (h_raw > YW'(MAX_HEIGHT)) begin
			h_sat = YW'(MAX_HEIGHT);
		end else begin
			h_sat = h_raw;
		end

		c_cur   = frame_start ? '0 : col_q;
		r_cur   = frame_start ? '0 : row_q;
		col_inc = CMPW'(c_cur) + CMPW'(1);
		wrap    = col_inc >= CMPW'(w_sat);
		c_next  = wrap ? '0 : col_inc[CW-1:0];
		r_inc   = wrap ? (RCMPW'(r_cur) + RCMPW'(1)) : RCMPW'(r_cur);
		// also catches a row count left beyond a smaller new height
		r_next  = (r_inc >= RCMPW'(h_sat)) ? '0 : r_inc[RW-1:0];

		cr_full = r_cur - RW'(KERN_HALF);
		cc_full = c_cur - CW'(KERN_HALF);
		meta_in.cv = (r_cur >= RW'(KERN_HALF)) && (c_cur >= CW'(KERN_HALF));
		meta_in.interior = (r_cur >= RW'(2 * KERN_HALF)) &&
			(RCMPW'(r_cur) < RCMPW'(h_sat)) &&
			(c_cur >= CW'(2 * KERN_HALF)) &&
			(CMPW'(c_cur) < CMPW'(w_sat));
		meta_in.cr = meta_in.cv ? COORD_W'(cr_full) : '0;
		meta_in.cc = meta_in.cv ? COORD_W'(cc_full) : '0;
	end

	// stage 1: line memory word arrives, column is formed and written back
	logic [PIX_W-1:0]  pix_s1;
	logic [RSEL_W-1:0] rsel_s1;
	logic [CW-1:0]     addr_s1;
	meta_t             meta_s1;
	row_word_t         rd_word, wr_word;
	logic [PIX_W-1:0]  colv [KW];
	logic              mem_wr;

	assign mem_wr = v1_q && ld2;

	ghp_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.rd_data (rd_word),
		.wr_en   (mem_wr),
		.wr_addr (addr_s1),
		.wr_data (wr_word)
	);

	always_comb begin
		logic [RSEL_W-1:0] idx;
		// oldest stored row first, the new pixel last
		for (int k = 0; k < NUM_ROWS; k++) begin
			idx     = rsel_s1 + RSEL_W'(k);
			colv[k] = rd_word[idx];
		end
		colv[KW-1]       = pix_s1;
		wr_word          = rd_word;
		wr_word[rsel_s1] = pix_s1;
	end

	// stage 2: window holds the item's 5x5 neighborhood
	logic [PIX_W-1:0] win_q [KW][KW];
	meta_t            meta_s2;

	// stage 3: per-class pixel sums
	logic [SUM_W-1:0] sums_c  [NUM_CLASS];
	logic [SUM_W-1:0] sums_s3 [NUM_CLASS];
	meta_t            meta_s3;

	always_comb begin
		for (int k = 0; k < NUM_CLASS; k++) begin
			sums_c[k] = '0;
		end
		for (int r = 0; r < KW; r++) begin
			for (int c = 0; c < KW; c++) begin
				sums_c[CLASS_MAP[r][c]] = sums_c[CLASS_MAP[r][c]] + SUM_W'(win_q[r][c]);
			end
		end
	end

	// stage 4: class products
	logic [PW-1:0]    prod_s4 [NUM_CLASS];
	logic [PIX_W-1:0] ctr_s4;
	meta_t            meta_s4;

	// stage 5: accumulate
	logic [PSW-1:0]          psum;
	logic signed [ACC_W-1:0] acc_c, acc_s5;
	meta_t                   meta_s5;

	always_comb begin
		psum = '0;
		for (int k = 0; k < NUM_CLASS; k++) begin
			psum = psum + PSW'(prod_s4[k]);
		end
		acc_c = $signed(ACC_W'(ctr_s4) << WEIGHT_BITS)
			+ $signed(ACC_W'(1) << (WEIGHT_BITS - 1))
			- $signed(ACC_W'(psum));
	end

	// output: round off, clamp, mask borders
	logic [QW-1:0]    q_c;
	logic [PIX_W-1:0] hp_c;
	logic [PIX_W-1:0] hp_q;
	meta_t            meta_o;

	always_comb begin
		q_c = acc_s5[ACC_W-1:WEIGHT_BITS];
		if (!meta_s5.interior || acc_s5[ACC_W-1]) begin
			hp_c = '0;
		end else if (q_c > QW'(255)) begin
			hp_c = '1;
		end else begin
			hp_c = q_c[PIX_W-1:0];
		end
	end

	// control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			v3_q  <= 1'b0;
			v4_q  <= 1'b0;
			v5_q  <= 1'b0;
			vo_q  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			for (int r = 0; r < KW; r++) begin
				for (int c = 0; c < KW; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (ld1)  v1_q <= pix_valid;
			if (ld2)  v2_q <= v1_q;
			if (ld3)  v3_q <= v2_q;
			if (ld4)  v4_q <= v3_q;
			if (ld5)  v5_q <= v4_q;
			if (ld_o) vo_q <= v5_q;
			if (accept) begin
				col_q <= c_next;
				row_q <= r_next;
			end
			if (mem_wr) begin
				for (int r = 0; r < KW; r++) begin
					for (int c = 0; c < KW - 1; c++) begin
						win_q[r][c] <= win_q[r][c + 1];
					end
					win_q[r][KW-1] <= colv[r];
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld1) begin
			pix_s1  <= pixel;
			rsel_s1 <= r_cur[RSEL_W-1:0];
			addr_s1 <= c_cur;
			meta_s1 <= meta_in;
		end
		if (ld2) begin
			meta_s2 <= meta_s1;
		end
		if (ld3) begin
			sums_s3 <= sums_c;
			meta_s3 <= meta_s2;
		end
		if (ld4) begin
			for (int k = 0; k < NUM_CLASS; k++) begin
				prod_s4[k] <= PW'(cfg.weight[k]) * PW'(sums_s3[k]);
			end
			ctr_s4  <= sums_s3[0][PIX_W-1:0];
			meta_s4 <= meta_s3;
		end
		if (ld5) begin
			acc_s5  <= acc_c;
			meta_s5 <= meta_s4;
		end
		if (ld_o) begin
			hp_q   <= hp_c;
			meta_o <= meta_s5;
		end
	end

	assign res_valid    = vo_q;
	assign hp_pixel     = hp_q;
	assign center_row   = meta_o.cr;
	assign center_col   = meta_o.cc;
	assign center_valid = meta_o.cv;

	`GHP_ASSERT(a_ready_only_on_stall, !pix_ready |-> (res_valid && !res_ready), "input stalled without an output stall")
	`GHP_ASSERT(a_no_centre_zero, (res_valid && !center_valid) |-> (hp_pixel == '0 && center_row == '0 && center_col == '0), "result without centre carries data")
	`GHP_ASSERT_NEXT(a_frame_restart, accept && frame_start, col_q == CW'(1) && row_q == '0, "frame start did not restart the counters")

endmodule

// File: tb/sv/gaussian_highpass_5x5_tb.sv
// ---------------------------------------------------------------------------
// gaussian_highpass_5x5_tb
// streams raster pixels through the 5x5 high-pass filter and checks every
// result beat against an in-bench model of the line buffers, window and
// rounding, over many frame sizes, weight sets and handshake stall patterns
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gaussian_highpass_5x5_tb;
	import ghp_pkg::*;

	localparam int LINE_MAX    = 1024;
	localparam int WEIGHT_FRAC = 16;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
		bit               drain;
	} pix_beat_t;

	typedef struct {
		logic [PIX_W-1:0]   hp;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               cv;
	} hp_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               pix_valid;
	logic               pix_ready;
	logic [PIX_W-1:0]   pixel;
	logic               frame_start;
	logic               res_valid;
	logic               res_ready;
	logic [PIX_W-1:0]   hp_pixel;
	logic [COORD_W-1:0] center_row;
	logic [COORD_W-1:0] center_col;
	logic               center_valid;

	pix_beat_t  pix_queue [$];
	hp_result_t hp_expect_q [$];

	int pix_offered;
	int pix_accepted;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_request;
	int hold_left;
	int err_count;

	// model state of the filter
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	logic [WGT_W-1:0]  wgt [6];
	logic [PIX_W-1:0]  line_mem [4][LINE_MAX];
	logic [PIX_W-1:0]  win [5][5];
	int                col_cnt;
	int                row_cnt;

	gaussian_highpass_5x5 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.hp_pixel     (hp_pixel),
		.center_row   (center_row),
		.center_col   (center_col),
		.center_valid (center_valid)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clip_size(int v);
		if (v < 5) return 5;
		if (v > LINE_MAX) return LINE_MAX;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] filter_window();
		longint acc;
		int d2;
		logic [WGT_W-1:0] wv;
		acc = longint'(win[2][2]) <<< WEIGHT_FRAC;
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				d2 = (r - 2) * (r - 2) + (c - 2) * (c - 2);
				case (d2)
					0: wv = wgt[0];
					1: wv = wgt[1];
					2: wv = wgt[2];
					4: wv = wgt[3];
					5: wv = wgt[4];
					default: wv = wgt[5];
				endcase
				acc -= longint'(wv) * longint'(win[r][c]);
			end
		end
		acc += longint'(1) <<< (WEIGHT_FRAC - 1);
		if (acc < 0) return '0;
		acc = acc >>> WEIGHT_FRAC;
		if (acc > 255) return 8'd255;
		return acc[PIX_W-1:0];
	endfunction

	task automatic predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
		hp_result_t res;
		logic [PIX_W-1:0] colv [5];
		int w;
		int h;
		int col;
		int cr;
		int cc;
		w = clip_size(int'(width_reg));
		h = clip_size(int'(height_reg));
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		col = (col_cnt < LINE_MAX) ? col_cnt : 0;
		for (int k = 0; k < 4; k++)
			colv[k] = line_mem[(row_cnt + k) % 4][col];
		colv[4] = px;
		line_mem[row_cnt % 4][col] = px;
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++)
				win[r][c] = win[r][c + 1];
			win[r][4] = colv[r];
		end
		res.hp  = '0;
		res.row = '0;
		res.col = '0;
		res.cv  = 1'b0;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			cr = row_cnt - 2;
			cc = col_cnt - 2;
			res.cv  = 1'b1;
			res.row = cr[COORD_W-1:0];
			res.col = cc[COORD_W-1:0];
			// border centres are forced to zero
			if (cr >= 2 && cr + 2 < h && cc >= 2 && cc + 2 < w)
				res.hp = filter_window();
		end
		hp_expect_q.push_back(res);
		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h) row_cnt = 0;
		end
		if (row_cnt >= h) row_cnt = 0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// pixel beats are taken here and fed to the model
	always @(posedge clk) begin : pix_accept
		if (arst_n && pix_valid && pix_ready) begin
			predict_pixel(pixel, frame_start);
			pix_accepted++;
		end
	end

	always @(negedge clk) begin : pix_driver
		pix_beat_t nb;
		logic v_n;
		logic [PIX_W-1:0] px_n;
		logic fs_n;
		v_n  = pix_valid;
		px_n = pixel;
		fs_n = frame_start;
		if (arst_n && !(pix_valid && pix_accepted != pix_offered)) begin
			v_n = 1'b0;
			if (pix_queue.size() != 0 && pix_queue[0].drain) begin
				// hold off until every pending result has come out
				if (hp_expect_q.size() == 0)
					void'(pix_queue.pop_front());
			end else if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nb   = pix_queue.pop_front();
				v_n  = 1'b1;
				px_n = nb.pixel;
				fs_n = nb.frame_start;
				pix_offered++;
			end
		end
		pix_valid   <= v_n;
		pixel       <= px_n;
		frame_start <= fs_n;
	end

	always @(negedge clk) begin : res_sink
		logic r;
		if (stall_request != 0) begin
			hold_left = stall_request;
			stall_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			r = 1'b0;
		end else begin
			r = ($urandom_range(99) >= recv_idle_pct);
		end
		res_ready <= r;
	end

	always @(posedge clk) begin : res_monitor
		hp_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (hp_expect_q.size() == 0) begin
				err_count++;
				$display("%0t ns: result beat with none expected, actual hp_pixel %0d",
					$time, hp_pixel);
			end else begin
				want = hp_expect_q.pop_front();
				check_field("hp_pixel", 16'(want.hp), 16'(hp_pixel));
				check_field("center_row", 16'(want.row), 16'(center_row));
				check_field("center_col", 16'(want.col), 16'(center_col));
				check_field("center_valid", 16'(want.cv), 16'(center_valid));
			end
		end
	end

	// one register write, then a read-back of the same register
	task automatic cfg_write(input logic [2:0] code, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] noise;
		mask  = (code == REG_IMAGE_WIDTH || code == REG_IMAGE_HEIGHT) ? 32'h7ff : 32'hffff;
		noise = $urandom() & ~mask;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {code, 2'b00};
		pwdata  <= (value & mask) | noise;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (code == REG_IMAGE_WIDTH)
			width_reg = value[SIZE_W-1:0];
		else if (code == REG_IMAGE_HEIGHT)
			height_reg = value[SIZE_W-1:0];
		else
			wgt[code - REG_WEIGHT_CENTER] = value[WGT_W-1:0];
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register read-back", 16'(value & mask), 16'(prdata & mask));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int wr, input int hr, input logic [WGT_W-1:0] wg [6]);
		cfg_write(REG_IMAGE_WIDTH, wr);
		cfg_write(REG_IMAGE_HEIGHT, hr);
		cfg_write(REG_WEIGHT_CENTER, 32'(wg[0]));
		cfg_write(REG_WEIGHT_EDGE1, 32'(wg[1]));
		cfg_write(REG_WEIGHT_DIAG1, 32'(wg[2]));
		cfg_write(REG_WEIGHT_EDGE2, 32'(wg[3]));
		cfg_write(REG_WEIGHT_KNIGHT, 32'(wg[4]));
		cfg_write(REG_WEIGHT_CORNER, 32'(wg[5]));
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pix_queue.size() != 0 || pix_valid || hp_expect_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic run_phase(input int n, input int fsize, input bit first_fs,
			input int noise_pct, input int mode, input int drain_at, input int stall);
		pix_beat_t b;
		case (mode)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 60; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 60; end
			default: begin send_idle_pct = 28; recv_idle_pct = 28; end
		endcase
		for (int i = 0; i < n; i++) begin
			if (i == drain_at) begin
				b.pixel = '0;
				b.frame_start = 1'b0;
				b.drain = 1'b1;
				pix_queue.push_back(b);
			end
			b.drain = 1'b0;
			b.pixel = rand_pixel();
			if (i == 0)
				b.frame_start = first_fs;
			else
				b.frame_start = (fsize > 0 && i % fsize == 0 && $urandom_range(1) == 1);
			// stray frame starts break the raster mid-frame
			if (i > 0 && $urandom_range(99) < noise_pct)
				b.frame_start = 1'b1;
			pix_queue.push_back(b);
		end
		if (stall != 0)
			stall_request = stall;
		wait_drained();
	endtask

	initial begin : stimulus
		logic [WGT_W-1:0] wg [6];
		pix_beat_t b;
		int wr;
		int hr;
		int n;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pix_valid   = 1'b0;
		pixel       = '0;
		frame_start = 1'b0;
		res_ready   = 1'b0;
		pix_offered   = 0;
		pix_accepted  = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 0;
		hold_left     = 0;
		err_count     = 0;
		width_reg  = 11'd1024;
		height_reg = 11'd1024;
		wgt = '{16'd10624, 16'd6443, 16'd3908, 16'd1438, 16'd872, 16'd195};
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < LINE_MAX; c++)
				line_mem[r][c] = '0;
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++)
				win[r][c] = '0;
		col_cnt = 0;
		row_cnt = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// one minimum 5x5 frame, sizes below range, weights left at reset
		cfg_write(REG_IMAGE_WIDTH, 3);
		cfg_write(REG_IMAGE_HEIGHT, 0);
		for (int i = 0; i < 25; i++) begin
			b.drain = 1'b0;
			b.frame_start = (i == 0);
			b.pixel = (i == 12 || i % 3 == 0) ? 8'd255 : 8'd0;
			pix_queue.push_back(b);
		end
		wait_drained();

		// small frames with assorted weight sets and stall patterns
		for (int p = 0; p < 12; p++) begin
			wr = $urandom_range(5, 6);
			hr = $urandom_range(5, 7);
			if (p == 1) wr = $urandom_range(0, 4);
			if (p == 2) hr = $urandom_range(0, 4);
			if (p == 10) hr = $urandom_range(1025, 2047);
			case (p)
				3: wg = '{default: 16'd0};
				4: wg = '{default: 16'hffff};
				5: wg = '{16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				6: wg = '{16'd10624, 16'd6443, 16'd3908, 16'd1438, 16'd872, 16'd195};
				7: for (int k = 0; k < 6; k++) wg[k] = WGT_W'($urandom_range(65535));
				default: begin
					wg[0] = WGT_W'($urandom_range(4096, 32767));
					for (int k = 1; k < 6; k++) wg[k] = WGT_W'($urandom_range(4095));
				end
			endcase
			set_config(wr, hr, wg);
			n = $urandom_range(20, 28);
			run_phase(n, clip_size(wr) * clip_size(hr), 1'b1, (p % 3 == 0) ? 3 : 0, p % 4,
				(p == 9) ? n / 2 : -1, (p == 8) ? 300 : 0);
		end

		// frame shrunk while counters sit beyond the new size
		wg[0] = WGT_W'($urandom_range(4096, 32767));
		for (int k = 1; k < 6; k++) wg[k] = WGT_W'($urandom_range(4095));
		set_config(12, 9, wg);
		run_phase(66, 108, 1'b1, 0, 3, -1, 0);
		set_config(7, 5, wg);
		run_phase(24, 35, 1'b0, 0, 1, -1, 0);

		// widest row, width register above range
		wg = '{16'd10624, 16'd6443, 16'd3908, 16'd1438, 16'd872, 16'd195};
		set_config(2047, 5, wg);
		run_phase(LINE_MAX + 40, 5 * LINE_MAX, 1'b1, 0, 0, -1, 0);

		// height register above range on a narrow frame
		for (int k = 0; k < 6; k++) wg[k] = WGT_W'($urandom_range(2047));
		set_config(6, 1500, wg);
		run_phase(30, 6 * LINE_MAX, 1'b1, 2, 3, -1, 0);

		wait_drained();
		repeat (12) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ghp_pkg.sv
hw/rtl/ghp_line_buf.sv
hw/rtl/ghp_regs.sv
hw/rtl/gaussian_highpass_5x5.sv
tb/sv/gaussian_highpass_5x5_tb.sv
